// ----- rtl/fpgs_pkg.sv -----
// Shared types, codes and constant tables of the fuzzy PD gain scheduler.
package fpgs_pkg;

    // Magnitude datapath width, wide enough for the default breakpoint width and fraction setting
    localparam int MAG_W       = 20;
    localparam int DEG_W       = 7;
    localparam int SET_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DEG_W-1:0] FULL_DEGREE = 7'd100;
    localparam logic [SET_W-1:0] SET_TOP     = 3'd4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_ERR_BREAKS  = 3'd0,
        CFG_RATE_BREAKS = 3'd1,
        CFG_P_GAINS     = 3'd2,
        CFG_D_GAINS     = 3'd3
    } t_cfg_idx;

    // Reset contents of the configuration registers, element by element
    localparam int ERR_BREAK_RST  [5] = '{0, 2, 4, 8, 12};
    localparam int RATE_BREAK_RST [5] = '{300, 400, 550, 700, 850};
    localparam int P_GAIN_RST     [5] = '{40, 45, 50, 55, 65};
    localparam int D_GAIN_RST     [5] = '{1, 1, 2, 3, 3};

    // Rule tables: P indexed [rate set][error set], D indexed [error set][rate set]
    localparam logic [SET_W-1:0] P_ROM [5][5] = '{
        '{3'd0, 3'd1, 3'd2, 3'd2, 3'd3},
        '{3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
        '{3'd1, 3'd2, 3'd3, 3'd3, 3'd3},
        '{3'd1, 3'd2, 3'd3, 3'd3, 3'd4},
        '{3'd2, 3'd3, 3'd3, 3'd3, 3'd4}
    };
    localparam logic [SET_W-1:0] D_ROM [5][5] = '{
        '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2},
        '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2},
        '{3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4},
        '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4}
    };

    // One fuzzified magnitude: lower set, segment offset and width
    typedef struct packed {
        logic [SET_W-1:0] set_lo;
        logic             full;    // above the last breakpoint
        logic             zero;    // zero-width first segment
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] w;
    } t_axis;

    typedef struct packed {
        logic  cmd;
        t_axis err;
        t_axis rate;
    } t_item;

endpackage

// ----- rtl/fpgs_front.sv -----
// Front end: takes an item, finds the segment of each magnitude and registers it.
module fpgs_front import fpgs_pkg::*; #(
    parameter int BREAK_WIDTH   = 12,
    parameter int FRACTION_BITS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [5*BREAK_WIDTH-1:0] i_err_breaks,
    input  logic [5*BREAK_WIDTH-1:0] i_rate_breaks,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cmd,
    input  logic signed [15:0]       i_error_value,
    input  logic signed [15:0]       i_error_rate,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_item                    o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Segment search over the five breakpoints of one axis
    function automatic t_axis fuzzify(input logic [15:0] raw,
                                      input logic [5*BREAK_WIDTH-1:0] brk);
        logic [15:0]      mag;
        logic [MAG_W-1:0] m;
        logic [MAG_W-1:0] b [5];
        t_axis            r;
        logic             found;
        mag = raw[15] ? (16'd0 - raw) : raw;
        for (int i = 0; i < 5; i++) begin
            b[i] = MAG_W'(brk[BREAK_WIDTH*i +: BREAK_WIDTH]) << FRACTION_BITS;
        end
        m = MAG_W'(mag);
        if (m < b[0]) begin
            m = b[0];
        end
        r        = '0;
        r.full   = 1'b1;
        r.set_lo = SET_TOP;
        found    = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!found && (m <= b[k+1])) begin
                found    = 1'b1;
                r.full   = 1'b0;
                r.set_lo = SET_W'(k);
                r.a      = m - b[k];
                r.w      = b[k+1] - b[k];
            end
        end
        r.zero = !r.full && (r.w == '0);
        return r;
    endfunction

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_item.cmd  = i_cmd;
        n_item.err  = fuzzify(i_error_value, i_err_breaks);
        n_item.rate = fuzzify(i_error_rate, i_rate_breaks);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/fpgs_queue.sv -----
// Short item queue between the front and back ends.
module fpgs_queue import fpgs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer wrap at the queue depth
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Fill level stays within the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

    // Fill level follows push and pop
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    // Pointers agree with the fill level when empty
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree when empty");

endmodule

// ----- rtl/fpgs_back.sv -----
// Back end: pipelined degree division, rule weighting and pipelined weighted average.
module fpgs_back import fpgs_pkg::*; #(
    parameter int GAIN_WIDTH = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [5*GAIN_WIDTH-1:0] i_p_gains,
    input  logic [5*GAIN_WIDTH-1:0] i_d_gains,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_item                   i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_gain
);

    localparam int REM_W = MAG_W + DEG_W;
    localparam int DEN_W = DEG_W + 2;
    localparam int NUM_W = GAIN_WIDTH + DEN_W;

    typedef struct packed {
        logic             cmd;
        logic [SET_W-1:0] e_set;
        logic [SET_W-1:0] r_set;
        logic             e_full;
        logic             e_zero;
        logic             r_full;
        logic             r_zero;
        logic [MAG_W-1:0] e_w;
        logic [MAG_W-1:0] r_w;
        logic [REM_W-1:0] e_rem;
        logic [REM_W-1:0] r_rem;
        logic [DEG_W-1:0] e_q;
        logic [DEG_W-1:0] r_q;
    } t_div;

    typedef struct packed {
        logic [NUM_W-1:0]      rem;
        logic [DEN_W-1:0]      den;
        logic [GAIN_WIDTH-1:0] q;
    } t_avg;

    t_div                  r_div [DEG_W+1];
    t_div                  n_div [DEG_W+1];
    logic [DEG_W:0]        r_dvld;
    t_avg                  r_avg [GAIN_WIDTH+1];
    t_avg                  n_avg [GAIN_WIDTH+1];
    logic [GAIN_WIDTH:0]   r_avld;
    logic                  en;
    logic [REM_W-1:0]      d_e;
    logic [REM_W-1:0]      d_r;
    logic [NUM_W-1:0]      d_a;
    logic [DEG_W-1:0]      deg_e [2];
    logic [DEG_W-1:0]      deg_r [2];
    logic [SET_W-1:0]      set_e [2];
    logic [SET_W-1:0]      set_r [2];
    logic [DEG_W-1:0]      wgt;
    logic [GAIN_WIDTH-1:0] lvl;
    logic [NUM_W-1:0]      num;
    logic [DEN_W-1:0]      den;

    // Whole pipeline advances unless the result is held
    assign en      = !r_avld[GAIN_WIDTH] || i_ready;
    assign o_ready = en;

    function automatic logic [GAIN_WIDTH-1:0] level(input logic [5*GAIN_WIDTH-1:0] g,
                                                    input logic [SET_W-1:0] idx);
        return g[GAIN_WIDTH*int'(idx) +: GAIN_WIDTH];
    endfunction

    // Degree division: restoring steps, one quotient bit per stage
    always_comb begin
        n_div[0]        = '0;
        n_div[0].cmd    = i_item.cmd;
        n_div[0].e_set  = i_item.err.set_lo;
        n_div[0].r_set  = i_item.rate.set_lo;
        n_div[0].e_full = i_item.err.full;
        n_div[0].e_zero = i_item.err.zero;
        n_div[0].r_full = i_item.rate.full;
        n_div[0].r_zero = i_item.rate.zero;
        n_div[0].e_w    = i_item.err.w;
        n_div[0].r_w    = i_item.rate.w;
        n_div[0].e_rem  = REM_W'(i_item.err.a) * REM_W'(FULL_DEGREE);
        n_div[0].r_rem  = REM_W'(i_item.rate.a) * REM_W'(FULL_DEGREE);
        d_e = '0;
        d_r = '0;
        for (int s = 0; s < DEG_W; s++) begin
            n_div[s+1] = r_div[s];
            d_e = REM_W'(r_div[s].e_w) << (DEG_W - 1 - s);
            d_r = REM_W'(r_div[s].r_w) << (DEG_W - 1 - s);
            if (r_div[s].e_rem >= d_e) begin
                n_div[s+1].e_rem = r_div[s].e_rem - d_e;
                n_div[s+1].e_q[DEG_W-1-s] = 1'b1;
            end
            if (r_div[s].r_rem >= d_r) begin
                n_div[s+1].r_rem = r_div[s].r_rem - d_r;
                n_div[s+1].r_q[DEG_W-1-s] = 1'b1;
            end
        end
    end

    // Degrees, rule weights and the weighted sums
    always_comb begin
        t_div f;
        f = r_div[DEG_W];
        deg_e[1] = (f.e_full || f.e_zero) ? FULL_DEGREE : f.e_q;
        deg_e[0] = f.e_full ? FULL_DEGREE : f.e_zero ? '0 :
                   FULL_DEGREE - f.e_q - DEG_W'(f.e_rem != '0);
        deg_r[1] = (f.r_full || f.r_zero) ? FULL_DEGREE : f.r_q;
        deg_r[0] = f.r_full ? FULL_DEGREE : f.r_zero ? '0 :
                   FULL_DEGREE - f.r_q - DEG_W'(f.r_rem != '0);
        set_e[0] = f.e_set;
        set_e[1] = f.e_full ? SET_TOP : f.e_set + 1'b1;
        set_r[0] = f.r_set;
        set_r[1] = f.r_full ? SET_TOP : f.r_set + 1'b1;
        num = '0;
        den = '0;
        wgt = '0;
        lvl = '0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                wgt = (deg_e[i] <= deg_r[j]) ? deg_e[i] : deg_r[j];
                lvl = f.cmd ? level(i_d_gains, D_ROM[set_e[i]][set_r[j]])
                            : level(i_p_gains, P_ROM[set_r[j]][set_e[i]]);
                num = num + NUM_W'(lvl) * NUM_W'(wgt);
                den = den + DEN_W'(wgt);
            end
        end
    end

    // Average division: restoring steps, one quotient bit per stage
    always_comb begin
        n_avg[0].rem = num;
        n_avg[0].den = den;
        n_avg[0].q   = '0;
        d_a = '0;
        for (int s = 0; s < GAIN_WIDTH; s++) begin
            n_avg[s+1] = r_avg[s];
            d_a = NUM_W'(r_avg[s].den) << (GAIN_WIDTH - 1 - s);
            if (r_avg[s].rem >= d_a) begin
                n_avg[s+1].rem = r_avg[s].rem - d_a;
                n_avg[s+1].q[GAIN_WIDTH-1-s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
            r_avld <= '0;
        end else if (en) begin
            r_dvld <= {r_dvld[DEG_W-1:0], i_valid};
            r_avld <= {r_avld[GAIN_WIDTH-1:0], r_dvld[DEG_W]};
        end
        if (en) begin
            for (int s = 0; s <= DEG_W; s++) begin
                r_div[s] <= n_div[s];
            end
            for (int s = 0; s <= GAIN_WIDTH; s++) begin
                r_avg[s] <= n_avg[s];
            end
        end
    end

    assign o_valid = r_avld[GAIN_WIDTH];
    assign o_gain  = 8'(r_avg[GAIN_WIDTH].q);

endmodule

// ----- rtl/fuzzy_pd_gain_scheduler_core.sv -----
// Top level of the fuzzy PD gain scheduler: configuration registers and the three stages.
//
// Each item (cmd, error, error rate) yields one gain. The block accepts an item every
// cycle unless back-pressure has filled the queue and the front register, and returns
// results in order. The two restoring dividers (membership degrees, then the weighted
// average) are fully pipelined, one quotient bit per stage.
// A held result stalls the back pipeline; the front register and a two-item queue keep
// taking items meanwhile. Configuration writes take effect at once and must be made idle.
module fuzzy_pd_gain_scheduler_core import fpgs_pkg::*; #(
    parameter int BREAK_WIDTH   = 12,
    parameter int GAIN_WIDTH    = 8,
    parameter int FRACTION_BITS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_index,
    input  logic [5*BREAK_WIDTH-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_cmd,
    input  logic signed [15:0]       i_error_value,
    input  logic signed [15:0]       i_error_rate,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_gain
);

    logic [5*BREAK_WIDTH-1:0] r_err_breaks;
    logic [5*BREAK_WIDTH-1:0] r_rate_breaks;
    logic [5*GAIN_WIDTH-1:0]  r_p_gains;
    logic [5*GAIN_WIDTH-1:0]  r_d_gains;

    logic  fr_valid;
    logic  fr_ready;
    t_item fr_item;
    logic  qb_valid;
    logic  qb_ready;
    t_item qb_item;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_err_breaks[BREAK_WIDTH*i +: BREAK_WIDTH]  <= BREAK_WIDTH'(ERR_BREAK_RST[i]);
                r_rate_breaks[BREAK_WIDTH*i +: BREAK_WIDTH] <= BREAK_WIDTH'(RATE_BREAK_RST[i]);
                r_p_gains[GAIN_WIDTH*i +: GAIN_WIDTH]       <= GAIN_WIDTH'(P_GAIN_RST[i]);
                r_d_gains[GAIN_WIDTH*i +: GAIN_WIDTH]       <= GAIN_WIDTH'(D_GAIN_RST[i]);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ERR_BREAKS:  r_err_breaks  <= i_cfg_data;
                CFG_RATE_BREAKS: r_rate_breaks <= i_cfg_data;
                CFG_P_GAINS:     r_p_gains     <= i_cfg_data[5*GAIN_WIDTH-1:0];
                CFG_D_GAINS:     r_d_gains     <= i_cfg_data[5*GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    fpgs_front #(
        .BREAK_WIDTH   (BREAK_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_err_breaks  (r_err_breaks),
        .i_rate_breaks (r_rate_breaks),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_cmd         (i_cmd),
        .i_error_value (i_error_value),
        .i_error_rate  (i_error_rate),
        .o_valid       (fr_valid),
        .i_ready       (fr_ready),
        .o_item        (fr_item)
    );

    fpgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_item  (fr_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    fpgs_back #(
        .GAIN_WIDTH (GAIN_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_p_gains (r_p_gains),
        .i_d_gains (r_d_gains),
        .i_valid   (qb_valid),
        .o_ready   (qb_ready),
        .i_item    (qb_item),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_gain    (o_gain)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the fuzzy PD gain scheduler core.
`timescale 1ns / 1ps

module testbench;
    import fpgs_pkg::*;

    localparam int WATCH_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic               cmd;
        logic signed [15:0] err;
        logic signed [15:0] rate;
        int                 want;   // typed-in gain, -1 when the predictor decides
    } t_stim;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [59:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_cmd = 1'b0;
    logic signed [15:0] i_error_value = '0;
    logic signed [15:0] i_error_rate = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_gain;

    fuzzy_pd_gain_scheduler_core uut (.*);

    // Shadow copy of the configuration registers
    logic [59:0] err_breaks, rate_breaks;
    logic [39:0] p_levels, d_levels;

    t_stim stim_q[$];
    int    gain_q[$];
    int    cur_want = -1;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    logic  hold_go = 1'b0;
    logic  hold_on = 1'b0;
    int    mismatches = 0;
    int    items_in = 0;
    int    results_out = 0;
    int    quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int break_of(logic [59:0] br, int i);
        return int'(br[12*i +: 12]) << 4;
    endfunction

    // Lower/upper fuzzy set and their truncated degrees for one magnitude
    function automatic void fuzzify(int m, logic [59:0] br, output int s_lo, output int s_hi,
                                    output int d_lo, output int d_hi);
        int lo_b, hi_b, w, a;
        if (m < break_of(br, 0)) m = break_of(br, 0);
        for (int k = 0; k < 4; k++) begin
            lo_b = break_of(br, k);
            hi_b = break_of(br, k + 1);
            if (m <= hi_b) begin
                w = hi_b - lo_b;
                a = m - lo_b;
                s_lo = k;
                s_hi = k + 1;
                if (w == 0) begin
                    d_hi = 100;
                    d_lo = 0;
                end else begin
                    d_hi = (100 * a) / w;
                    d_lo = (100 * (w - a)) / w;
                end
                return;
            end
        end
        s_lo = 4;
        s_hi = 4;
        d_lo = 100;
        d_hi = 100;
    endfunction

    function automatic int predict_gain(logic cmd, logic signed [15:0] e, logic signed [15:0] r);
        int em, rm, xs[2], ys[2], xd[2], yd[2], w, g;
        longint num, den;
        em = (int'(e) < 0) ? -int'(e) : int'(e);
        rm = (int'(r) < 0) ? -int'(r) : int'(r);
        fuzzify(em, err_breaks, xs[0], xs[1], xd[0], xd[1]);
        fuzzify(rm, rate_breaks, ys[0], ys[1], yd[0], yd[1]);
        num = 0;
        den = 0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                w = (xd[i] <= yd[j]) ? xd[i] : yd[j];
                if (cmd) g = int'(d_levels[8*D_ROM[xs[i]][ys[j]] +: 8]);
                else     g = int'(p_levels[8*P_ROM[ys[j]][xs[i]] +: 8]);
                num += longint'(g) * w;
                den += w;
            end
        end
        return (den != 0) ? int'((num / den) & 255) : 0;
    endfunction

    // Receiver readiness, with an optional long hold-off
    always @(posedge i_clk) begin
        i_out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    always begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
        hold_go = 1'b0;
    end

    // Record expected gain for each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            gain_q.push_back(cur_want >= 0 ? cur_want
                             : predict_gain(i_cmd, i_error_value, i_error_rate));
            items_in++;
        end
    end

    // Compare each result with the oldest expected gain
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_out++;
            if (gain_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result gain=%0d", o_gain);
            end else begin
                if (int'(o_gain) != gain_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("gain mismatch: expected %0d actual %0d", gain_q[0], o_gain);
                end
                void'(gain_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without an accepted item, a taken result or a configuration write
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [59:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_ERR_BREAKS:  err_breaks  = value;
            CFG_RATE_BREAKS: rate_breaks = value;
            CFG_P_GAINS:     p_levels    = value[39:0];
            CFG_D_GAINS:     d_levels    = value[39:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender: drains the stimulus queue, honoring the idle percentage
    task automatic send_all();
        t_stim s;
        logic  taken;
        forever begin
            @(posedge i_clk);
            taken = i_in_valid && o_in_ready;
            if (!i_in_valid || taken) begin
                if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s = stim_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_cmd         <= s.cmd;
                    i_error_value <= s.err;
                    i_error_rate  <= s.rate;
                    cur_want      <= s.want;
                end else begin
                    i_in_valid <= 1'b0;
                    if (stim_q.size() == 0) break;
                end
            end
        end
        // let the last accepted item reach the expected queue first
        @(posedge i_clk);
        wait (gain_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Magnitude drawn from noise, around a breakpoint, or up to 40 above the last breakpoint
    function automatic logic signed [15:0] pick_value(logic [59:0] br);
        int m;
        case ($urandom_range(2))
            0: return 16'($urandom);
            1: m = break_of(br, $urandom_range(4)) + $urandom_range(32) - 16;
            default: m = $urandom_range(break_of(br, 4) + 40);
        endcase
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
        return 16'($urandom_range(1) ? -m : m);
    endfunction

    task automatic add_random(int n);
        t_stim s;
        repeat (n) begin
            s.cmd  = $urandom_range(1);
            s.err  = pick_value(err_breaks);
            s.rate = pick_value(rate_breaks);
            s.want = -1;
            stim_q.push_back(s);
        end
    endtask

    function automatic logic [59:0] pack_breaks(int b[5]);
        logic [59:0] v = '0;
        for (int i = 0; i < 5; i++) v[12*i +: 12] = 12'(b[i]);
        return v;
    endfunction

    function automatic logic [59:0] sorted_breaks(int span, logic dup_first);
        int b[5], t;
        for (int i = 0; i < 5; i++) b[i] = $urandom_range(span);
        for (int i = 1; i < 5; i++)
            for (int j = i; j > 0 && b[j-1] > b[j]; j--) begin
                t = b[j]; b[j] = b[j-1]; b[j-1] = t;
            end
        if (dup_first) b[1] = b[0];
        return pack_breaks(b);
    endfunction

    task automatic set_config(logic [59:0] eb, logic [59:0] rb, logic [39:0] pg, logic [39:0] dg);
        write_reg(CFG_ERR_BREAKS, eb);
        write_reg(CFG_RATE_BREAKS, rb);
        write_reg(CFG_P_GAINS, {20'd0, pg});
        write_reg(CFG_D_GAINS, {20'd0, dg});
    endtask

    task automatic set_idle(int snd, int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    // Directed items under reset configuration; gains typed where obvious
    t_stim directed[] = '{
        '{1'b0, 16'sd0,      16'sd0,      40},
        '{1'b1, 16'sd0,      16'sd0,      1},
        '{1'b0, 16'sd32767,  16'sd32767,  65},
        '{1'b1, 16'sd32767,  16'sd32767,  3},
        '{1'b0, -16'sd32768, -16'sd32768, 65},
        '{1'b1, -16'sd32768, 16'sd32767,  3},
        '{1'b0, 16'sd32,     16'sd4800,   -1},
        '{1'b1, -16'sd32,    -16'sd6400,  -1},
        '{1'b0, 16'sd100,    16'sd7000,   -1},
        '{1'b1, 16'sd100,    16'sd7000,   -1},
        '{1'b0, -16'sd1,     16'sd1,      -1},
        '{1'b1, 16'sd192,    16'sd13600,  -1},
        '{1'b0, 16'sd193,    16'sd13601,  -1},
        '{1'b1, 16'sd150,    -16'sd11000, -1},
        '{1'b0, 16'sd48,     16'sd0,      -1},
        '{1'b1, 16'sd0,      -16'sd9000,  -1}
    };

    initial begin
        err_breaks  = 60'd3378249543458816;
        rate_breaks = 60'd239301843066880300;
        p_levels    = 40'd280098909480;
        d_levels    = 40'd12935364865;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: directed table, then random with no idling
        set_idle(0, 0);
        foreach (directed[k]) stim_q.push_back(directed[k]);
        add_random(60);
        send_all();

        // All-zero registers: every nonzero magnitude lands above the last breakpoint
        set_config('0, '0, '0, '0);
        set_idle(50, 0);
        add_random(60);
        send_all();

        // All-ones registers: everything clamps into a zero-width first segment
        set_config({60{1'b1}}, {60{1'b1}}, {40{1'b1}}, {40{1'b1}});
        set_idle(0, 50);
        add_random(60);
        send_all();

        // Zero-width first segment inside a sorted set; receiver held off to fill the pipe
        set_config(sorted_breaks(1500, 1'b1), sorted_breaks(2000, 1'b1),
                   40'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        set_idle(0, 0);
        hold_go = 1'b1;
        add_random(80);
        send_all();

        // Unordered breakpoints
        set_config(60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                   40'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        set_idle(27, 27);
        add_random(80);
        send_all();

        // Sorted random breakpoints and gains, mixed idling
        set_config(sorted_breaks(2047, 1'b0), sorted_breaks(2047, 1'b0),
                   40'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        set_idle(50, 50);
        add_random(80);
        send_all();

        $display("run covered %0d items and %0d gains over six register settings,",
                 items_in, results_out);
        $display("with sender gaps, receiver stalls and a long back-pressure hold; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && gain_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
